### rtl/i2cr_pkg.sv
// ----------------------------------------------------------------------------
// i2cr_pkg
// Shared types and constants for the I2C register read master.
// ----------------------------------------------------------------------------
package i2cr_pkg;

    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam logic [7:0]  HALF_PERIOD_RST = 8'd4;
    localparam logic [7:0]  MSB_MASK        = 8'h80;
    localparam logic [7:0]  WRITE_MASK      = 8'hfe;
    localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

    // input opcodes
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_CUR_READ = 2'd1;
    localparam logic [1:0] OP_REG_READ = 2'd2;

    // command class decided by the front end
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_CUR_READ = 2'd1,
        CMD_REG_READ = 2'd2
    } t_cmd;

    // byte being sent or read; doubles as the reported status
    typedef enum logic [1:0] {
        STAGE_READ  = 2'd0,
        STAGE_ADDR  = 2'd1,
        STAGE_REG   = 2'd2,
        STAGE_RADDR = 2'd3
    } t_stage;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_S_SDA1 = 5'd1,
        PH_S_SCL1 = 5'd2,
        PH_S_SDA0 = 5'd3,
        PH_S_SCL0 = 5'd4,
        PH_T_SDA  = 5'd5,
        PH_T_SCLH = 5'd6,
        PH_T_SCLL = 5'd7,
        PH_A_SDA1 = 5'd8,
        PH_A_SCLH = 5'd9,
        PH_A_SCLL = 5'd10,
        PH_R_SDA1 = 5'd11,
        PH_R_SCLH = 5'd12,
        PH_R_SCLL = 5'd13,
        PH_N_SDA  = 5'd14,
        PH_N_SCLH = 5'd15,
        PH_N_SCLL = 5'd16,
        PH_P_SDA0 = 5'd17,
        PH_P_SCL1 = 5'd18,
        PH_P_SDA1 = 5'd19,
        PH_FINISH = 5'd20
    } t_phase;

    // one classified tick held in the queue
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] dev;
        logic [7:0] reg_addr;
        logic       sda;
    } t_item;

    // queue head handed to the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

### rtl/i2cr_front.sv
// ----------------------------------------------------------------------------
// i2cr_front
// Accepts tick requests, classifies the opcode and queues them for the
// bus sequencer.
// ----------------------------------------------------------------------------
module i2cr_front
    import i2cr_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_device_addr,
    input  logic [7:0] i_register_addr,
    input  logic       i_sda_in,
    output t_head      o_head,
    input  logic       i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;
    t_item            new_item;

    always_comb begin
        new_item.dev      = i_device_addr;
        new_item.reg_addr = i_register_addr;
        new_item.sda      = i_sda_in;
        case (i_opcode)
            OP_CUR_READ: new_item.cmd = CMD_CUR_READ;
            OP_REG_READ: new_item.cmd = CMD_REG_READ;
            default:     new_item.cmd = CMD_TICK;
        endcase
    end

    assign o_in_stall  = (r_count == FULL_CNT);
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_pop && o_head.valid;
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty queue with pointers apart");
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FULL_CNT) |-> (r_rd_ptr == r_wr_ptr))
        else $error("full queue with pointers apart");
`endif

endmodule

### rtl/i2cr_back.sv
// ----------------------------------------------------------------------------
// i2cr_back
// Bus sequencer: runs one tick per queued request through the START, byte,
// acknowledge, read and STOP phases and registers one result per tick.
// ----------------------------------------------------------------------------
module i2cr_back
    import i2cr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_half_period,
    input  t_head      i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [1:0] o_status,
    output logic [7:0] o_read_data
);

    logic [7:0] r_half_period;
    t_phase     r_phase, n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_wait, n_wait;
    logic [7:0] r_saved_dev, n_saved_dev;
    logic [7:0] r_saved_reg, n_saved_reg;
    logic       r_read_mode, n_read_mode;
    t_stage     r_stage, n_stage;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       done;
    logic [3:0] bit_inc;
    t_item      it;

    logic       r_out_valid;
    logic       r_scl_out, r_sda_out, r_busy_out, r_done_out;
    logic [1:0] r_status_out;
    logic [7:0] r_data_out;

    assign o_cfg_ready = 1'b1;
    assign it          = i_head.item;
    assign o_pop       = i_head.valid && (!r_out_valid || !i_out_stall);
    assign bit_inc     = r_bit_count + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_saved_dev = r_saved_dev;
        n_saved_reg = r_saved_reg;
        n_read_mode = r_read_mode;
        n_stage     = r_stage;
        n_scl       = r_scl;
        n_sda       = r_sda;
        done        = 1'b0;
        if (r_phase == PH_IDLE) begin
            // a command starts with its first START step on the same tick
            if (it.cmd == CMD_CUR_READ || it.cmd == CMD_REG_READ) begin
                n_saved_dev = it.dev;
                n_saved_reg = it.reg_addr;
                n_read_mode = (it.cmd == CMD_REG_READ);
                n_stage     = STAGE_ADDR;
                n_bit_count = '0;
                n_shift     = (it.cmd == CMD_REG_READ) ? (it.dev & WRITE_MASK)
                                                       : (it.dev | 8'h01);
                n_sda       = 1'b1;
                n_wait      = r_half_period;
                n_phase     = PH_S_SCL1;
            end
        end else if (r_wait != '0) begin
            n_wait = r_wait - 1'b1;
        end else begin
            n_wait = r_half_period;
            case (r_phase)
                PH_S_SDA1: begin n_sda = 1'b1; n_phase = PH_S_SCL1; end
                PH_S_SCL1: begin n_scl = 1'b1; n_phase = PH_S_SDA0; end
                PH_S_SDA0: begin n_sda = 1'b0; n_phase = PH_S_SCL0; end
                PH_S_SCL0: begin
                    n_scl       = 1'b0;
                    n_bit_count = '0;
                    n_phase     = PH_T_SDA;
                end
                PH_T_SDA: begin
                    n_sda   = |(r_shift & MSB_MASK);
                    n_phase = PH_T_SCLH;
                end
                PH_T_SCLH: begin n_scl = 1'b1; n_phase = PH_T_SCLL; end
                PH_T_SCLL: begin
                    n_scl   = 1'b0;
                    n_shift = {r_shift[6:0], 1'b0};
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_bit_count = '0;
                        n_phase     = PH_A_SDA1;
                    end else begin
                        n_bit_count = bit_inc;
                        n_phase     = PH_T_SDA;
                    end
                end
                PH_A_SDA1: begin n_sda = 1'b1; n_phase = PH_A_SCLH; end
                PH_A_SCLH: begin n_scl = 1'b1; n_phase = PH_A_SCLL; end
                PH_A_SCLL: begin
                    n_scl   = 1'b0;
                    n_phase = PH_P_SDA0;
                    // ack low: move on to the next byte, else straight to stop
                    if (!it.sda) begin
                        if (r_stage == STAGE_ADDR && r_read_mode) begin
                            n_stage = STAGE_REG;
                            n_shift = r_saved_reg;
                            n_phase = PH_T_SDA;
                        end else if (r_stage == STAGE_REG) begin
                            n_stage = STAGE_RADDR;
                            n_shift = r_saved_dev | 8'h01;
                            n_phase = PH_S_SDA1;
                        end else begin
                            n_stage = STAGE_READ;
                            n_shift = '0;
                            n_phase = PH_R_SDA1;
                        end
                    end
                end
                PH_R_SDA1: begin n_sda = 1'b1; n_phase = PH_R_SCLH; end
                PH_R_SCLH: begin n_scl = 1'b1; n_phase = PH_R_SCLL; end
                PH_R_SCLL: begin
                    n_scl   = 1'b0;
                    n_shift = {r_shift[6:0], it.sda};
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_bit_count = '0;
                        n_phase     = PH_N_SDA;
                    end else begin
                        n_bit_count = bit_inc;
                        n_phase     = PH_R_SDA1;
                    end
                end
                PH_N_SDA:  begin n_sda = 1'b1; n_phase = PH_N_SCLH; end
                PH_N_SCLH: begin n_scl = 1'b1; n_phase = PH_N_SCLL; end
                PH_N_SCLL: begin n_scl = 1'b0; n_phase = PH_P_SDA0; end
                PH_P_SDA0: begin n_sda = 1'b0; n_phase = PH_P_SCL1; end
                PH_P_SCL1: begin n_scl = 1'b1; n_phase = PH_P_SDA1; end
                PH_P_SDA1: begin n_sda = 1'b1; n_phase = PH_FINISH; end
                PH_FINISH: begin
                    n_wait  = r_wait;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                default: begin
                    n_wait  = r_wait;
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_phase       <= PH_IDLE;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_wait        <= '0;
            r_saved_dev   <= '0;
            r_saved_reg   <= '0;
            r_read_mode   <= 1'b0;
            r_stage       <= STAGE_READ;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_half_period <= i_cfg_half_period;
            end
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_wait      <= n_wait;
                r_saved_dev <= n_saved_dev;
                r_saved_reg <= n_saved_reg;
                r_read_mode <= n_read_mode;
                r_stage     <= n_stage;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each popped request
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_scl_out    <= n_scl;
            r_sda_out    <= n_sda;
            r_busy_out   <= (n_phase != PH_IDLE);
            r_done_out   <= done;
            r_status_out <= done ? n_stage : STAGE_READ;
            r_data_out   <= (done && n_stage == STAGE_READ) ? n_shift : 8'h00;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_scl_out;
    assign o_sda_level = r_sda_out;
    assign o_busy_res  = r_busy_out;
    assign o_done_res  = r_done_out;
    assign o_status    = r_status_out;
    assign o_read_data = r_data_out;

`ifndef SYNTH
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_wait == '0))
        else $error("wait count left over in idle");
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_scl && r_sda))
        else $error("bus not released in idle");
    a_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count < BITS_PER_BYTE)
        else $error("bit count out of range");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && done) |=> (r_phase == PH_IDLE))
        else $error("finish without returning to idle");
`endif

endmodule

### rtl/i2c_master_register_read.sv
// ----------------------------------------------------------------------------
// i2c_master_register_read
// I2C master for current-address and register reads, one bus tick per request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       in         i_in_valid / o_in_stall    opcode, device_addr,
//                                                  register_addr, sda_in
//  out      out        o_out_valid / i_out_stall  scl_level, sda_level, busy_res,
//                                                  done_res, status, read_data
//  cfg      in         i_cfg_valid / o_cfg_ready  half_period
//
//  one request per cycle sustained while the output does not stall; a request
//  leaves as a result through the queue and the sequencer's output register
//  the sequencer step plus its output register set the one-per-cycle figure
//  synchronous active-low reset; bus lines come up released, half period 4
//  an output stall holds the result; the queue of QUEUE_DEPTH requests then
//  fills and the input stalls
//  cfg writes are always taken and apply from the next sequencer step
// ----------------------------------------------------------------------------
module i2c_master_register_read
    import i2cr_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_device_addr,
    input  logic [7:0] i_register_addr,
    input  logic       i_sda_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [1:0] o_status,
    output logic [7:0] o_read_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_half_period
);

    t_head head;
    logic  pop;

    i2cr_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_device_addr  (i_device_addr),
        .i_register_addr(i_register_addr),
        .i_sda_in       (i_sda_in),
        .o_head         (head),
        .i_pop          (pop)
    );

    i2cr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_half_period(i_cfg_half_period),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_scl_level      (o_scl_level),
        .o_sda_level      (o_sda_level),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_status         (o_status),
        .o_read_data      (o_read_data)
    );

endmodule

### tb/sv/i2cr_bus_checker.sv
// ----------------------------------------------------------------------------
// i2cr_bus_checker
// Watches the request, result and config channels of the I2C register read
// master, predicts the bus levels and status for every request and compares
// each result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module i2cr_bus_checker
    import i2cr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_device_addr,
    input  logic [7:0] i_register_addr,
    input  logic       i_sda_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_scl_level,
    input  logic       i_sda_level,
    input  logic       i_busy_res,
    input  logic       i_done_res,
    input  logic [1:0] i_status,
    input  logic [7:0] i_read_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_half_period,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked,
    output int         o_transfers,
    output int         o_reads_ok
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   MAX_REPORTS = 10;
    localparam logic SCL_LINE    = 1'b1;
    localparam logic SDA_LINE    = 1'b0;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [1:0] status;
        logic [7:0] data;
    } t_bus_sample;

    t_bus_sample bus_samples_due[$];

    // predicted master state
    t_phase     ph;
    t_stage     stage;
    logic [3:0] nbits;
    logic [7:0] shreg;
    logic [7:0] hold_cnt;
    logic [7:0] dev_q;
    logic [7:0] reg_q;
    logic [7:0] half_q;
    logic       reg_mode;
    logic       scl_q;
    logic       sda_q;

    int errors    = 0;
    int checked   = 0;
    int transfers = 0;
    int reads_ok  = 0;

    assign o_errors    = errors;
    assign o_checked   = checked;
    assign o_transfers = transfers;
    assign o_reads_ok  = reads_ok;

    function automatic string show(input t_bus_sample s);
        return $sformatf("scl=%b sda=%b busy=%b done=%b status=%0d data=%02h",
                         s.scl, s.sda, s.busy, s.done, s.status, s.data);
    endfunction

    function automatic void note_fault(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    task automatic line_change(input logic on_scl, input logic level, input t_phase nxt);
        if (on_scl) begin
            scl_q = level;
        end else begin
            sda_q = level;
        end
        hold_cnt = half_q;
        ph       = nxt;
    endtask

    // one line step of the bus sequencer
    task automatic bus_step(input logic sda_i, output logic fin);
        fin = 1'b0;
        case (ph)
            PH_S_SDA1: line_change(SDA_LINE, 1'b1, PH_S_SCL1);
            PH_S_SCL1: line_change(SCL_LINE, 1'b1, PH_S_SDA0);
            PH_S_SDA0: line_change(SDA_LINE, 1'b0, PH_S_SCL0);
            PH_S_SCL0: begin
                line_change(SCL_LINE, 1'b0, PH_T_SDA);
                nbits = 4'd0;
            end
            PH_T_SDA:  line_change(SDA_LINE, |(shreg & MSB_MASK), PH_T_SCLH);
            PH_T_SCLH: line_change(SCL_LINE, 1'b1, PH_T_SCLL);
            PH_T_SCLL: begin
                shreg = shreg << 1;
                nbits = nbits + 4'd1;
                if (nbits >= BITS_PER_BYTE) begin
                    nbits = 4'd0;
                    line_change(SCL_LINE, 1'b0, PH_A_SDA1);
                end else begin
                    line_change(SCL_LINE, 1'b0, PH_T_SDA);
                end
            end
            PH_A_SDA1: line_change(SDA_LINE, 1'b1, PH_A_SCLH);
            PH_A_SCLH: line_change(SCL_LINE, 1'b1, PH_A_SCLL);
            PH_A_SCLL: begin
                // nak falls through to stop with the stage kept as status
                line_change(SCL_LINE, 1'b0, PH_P_SDA0);
                if (!sda_i) begin
                    if (stage == STAGE_ADDR && reg_mode) begin
                        stage = STAGE_REG;
                        shreg = reg_q;
                        ph    = PH_T_SDA;
                    end else if (stage == STAGE_REG) begin
                        stage = STAGE_RADDR;
                        shreg = dev_q | 8'h01;
                        ph    = PH_S_SDA1;
                    end else begin
                        stage = STAGE_READ;
                        shreg = 8'h00;
                        ph    = PH_R_SDA1;
                    end
                end
            end
            PH_R_SDA1: line_change(SDA_LINE, 1'b1, PH_R_SCLH);
            PH_R_SCLH: line_change(SCL_LINE, 1'b1, PH_R_SCLL);
            PH_R_SCLL: begin
                shreg = {shreg[6:0], sda_i};
                nbits = nbits + 4'd1;
                if (nbits >= BITS_PER_BYTE) begin
                    nbits = 4'd0;
                    line_change(SCL_LINE, 1'b0, PH_N_SDA);
                end else begin
                    line_change(SCL_LINE, 1'b0, PH_R_SDA1);
                end
            end
            PH_N_SDA:  line_change(SDA_LINE, 1'b1, PH_N_SCLH);
            PH_N_SCLH: line_change(SCL_LINE, 1'b1, PH_N_SCLL);
            PH_N_SCLL: line_change(SCL_LINE, 1'b0, PH_P_SDA0);
            PH_P_SDA0: line_change(SDA_LINE, 1'b0, PH_P_SCL1);
            PH_P_SCL1: line_change(SCL_LINE, 1'b1, PH_P_SDA1);
            PH_P_SDA1: line_change(SDA_LINE, 1'b1, PH_FINISH);
            PH_FINISH: begin
                ph  = PH_IDLE;
                fin = 1'b1;
            end
            default:   ph = PH_IDLE;
        endcase
    endtask

    task automatic master_tick(input logic [1:0] op, input logic [7:0] dev,
                               input logic [7:0] rga, input logic sda_i,
                               output t_bus_sample due);
        logic fin;
        fin = 1'b0;
        if (ph == PH_IDLE) begin
            if (op == OP_CUR_READ || op == OP_REG_READ) begin
                dev_q    = dev;
                reg_q    = rga;
                reg_mode = (op == OP_REG_READ);
                stage    = STAGE_ADDR;
                nbits    = 4'd0;
                hold_cnt = 8'd0;
                shreg    = reg_mode ? (dev & WRITE_MASK) : (dev | 8'h01);
                ph       = PH_S_SDA1;
                // first line change lands on the accepting tick
                bus_step(sda_i, fin);
                fin = 1'b0;
            end
        end else if (hold_cnt != 8'd0) begin
            hold_cnt = hold_cnt - 8'd1;
        end else begin
            bus_step(sda_i, fin);
        end
        due.scl    = scl_q;
        due.sda    = sda_q;
        due.busy   = (ph != PH_IDLE);
        due.done   = fin;
        due.status = fin ? stage : 2'd0;
        due.data   = (fin && stage == STAGE_READ) ? shreg : 8'h00;
    endtask

    always @(posedge i_clk) begin : watch
        t_bus_sample due;
        t_bus_sample seen;
        if (!i_rst_n) begin
            ph       = PH_IDLE;
            stage    = STAGE_READ;
            nbits    = 4'd0;
            shreg    = 8'h00;
            hold_cnt = 8'd0;
            dev_q    = 8'h00;
            reg_q    = 8'h00;
            reg_mode = 1'b0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            half_q   = HALF_PERIOD_RST;
            bus_samples_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_scl_level, i_sda_level, i_busy_res, i_done_res,
                         i_status, i_read_data};
                if (bus_samples_due.size() == 0) begin
                    note_fault({"result with no request pending: ", show(seen)});
                end else begin
                    due = bus_samples_due.pop_front();
                    if (seen.scl !== due.scl || seen.sda !== due.sda
                        || seen.busy !== due.busy || seen.done !== due.done
                        || seen.status !== due.status || seen.data !== due.data) begin
                        note_fault($sformatf("result %0d mismatch: expected %s, got %s",
                                             checked, show(due), show(seen)));
                    end
                end
                checked++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                half_q = i_cfg_half_period;
            end
            if (i_in_valid && !i_in_stall) begin
                master_tick(i_opcode, i_device_addr, i_register_addr, i_sda_in, due);
                if (due.done) begin
                    transfers++;
                    if (due.status == STAGE_READ) begin
                        reads_ok++;
                    end
                end
                bus_samples_due.push_back(due);
            end
        end
        o_pending = bus_samples_due.size();
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives bus ticks, commands and half-period writes into the I2C register
// read master with random gaps and output stalls; the checker beside it
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cr_pkg::*;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [7:0]  HALF_MAX    = 8'd255;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] opcode;
    logic [7:0] device_addr;
    logic [7:0] register_addr;
    logic       sda_in;
    logic       out_valid;
    logic       out_stall;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_half_period;

    int errors;
    int pending;
    int checked;
    int transfers;
    int reads_ok;

    int unsigned cycle_count = 0;
    logic        calm        = 1'b0;

    i2c_master_register_read u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_opcode          (opcode),
        .i_device_addr     (device_addr),
        .i_register_addr   (register_addr),
        .i_sda_in          (sda_in),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_scl_level       (scl_level),
        .o_sda_level       (sda_level),
        .o_busy_res        (busy_res),
        .o_done_res        (done_res),
        .o_status          (status),
        .o_read_data       (read_data),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_half_period (cfg_half_period)
    );

    i2cr_bus_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_opcode          (opcode),
        .i_device_addr     (device_addr),
        .i_register_addr   (register_addr),
        .i_sda_in          (sda_in),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_scl_level       (scl_level),
        .i_sda_level       (sda_level),
        .i_busy_res        (busy_res),
        .i_done_res        (done_res),
        .i_status          (status),
        .i_read_data       (read_data),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_half_period (cfg_half_period),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_transfers       (transfers),
        .o_reads_ok        (reads_ok)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
        $display("== FAIL ==");
        $finish;
    end

    // mostly short gaps, now and then a long one; none in calm stretches
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    initial begin
        int gap;
        out_stall = 1'b0;
        @(negedge clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                out_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] op, input logic [7:0] dev,
                                input logic [7:0] rga, input logic sda);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        opcode        = op;
        device_addr   = dev;
        register_addr = rga;
        sda_in        = sda;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_half(input logic [7:0] value);
        drain();
        cfg_valid       = 1'b1;
        cfg_half_period = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // the slave side is a biased sda level: mostly acks, plain noise, or mostly naks
    task automatic send_random(input int count);
        int         bias;
        int         bias_left;
        int         roll;
        logic [1:0] op;
        logic       sda;
        bias_left = 0;
        bias      = 0;
        repeat (count) begin
            if (bias_left == 0) begin
                roll      = $urandom_range(0, 99);
                bias      = (roll < 65) ? 0 : (roll < 88) ? 1 : 2;
                bias_left = $urandom_range(30, 200);
            end
            bias_left--;
            case (bias)
                0:       sda = ($urandom_range(0, 9) == 0);
                1:       sda = $urandom_range(0, 1);
                default: sda = ($urandom_range(0, 6) != 0);
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                op = OP_TICK;
            end else if (roll < 75) begin
                op = OP_CUR_READ;
            end else if (roll < 95) begin
                op = OP_REG_READ;
            end else begin
                op = OP_UNUSED;
            end
            send_request(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sda);
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        opcode          = OP_TICK;
        device_addr     = 8'h00;
        register_addr   = 8'h00;
        sda_in          = 1'b1;
        cfg_valid       = 1'b0;
        cfg_half_period = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle ticks, unused opcode, commands while busy, reset half period
        send_request(OP_TICK, 8'h00, 8'h00, 1'b0);
        send_request(OP_UNUSED, 8'hff, 8'hff, 1'b1);
        send_request(OP_CUR_READ, 8'hfe, 8'h00, 1'b1);
        send_request(OP_REG_READ, 8'h55, 8'haa, 1'b0);
        send_request(OP_CUR_READ, 8'h00, 8'hff, 1'b0);
        send_request(OP_UNUSED, 8'haa, 8'h55, 1'b1);
        repeat (8) send_request(OP_TICK, 8'hff, 8'hff, 1'b0);
        // zero half period applied while that transfer is still on the bus
        write_half(8'd0);
        send_request(OP_REG_READ, 8'h01, 8'h80, 1'b0);
        repeat (6) send_request(OP_TICK, 8'h00, 8'h00, 1'b0);

        send_random(150);
        drain();
        send_random(250);
        write_half(8'd1);
        send_random(300);
        write_half(HALF_MAX);
        send_random(150);
        write_half(8'd0);
        calm = 1'b1;
        send_random(300);
        calm = 1'b0;
        write_half(8'd2);
        send_random(300);
        write_half(8'($urandom_range(3, 6)));
        send_random(200);
        write_half(8'd0);
        send_random(350);

        drain();
        repeat (8) @(posedge clk);
        $display("checked %0d bus ticks with half periods 0, 1, 2, 4, 255 and one random",
                 checked);
        $display("%0d transfers finished: %0d reads completed, %0d stopped on a nak",
                 transfers, reads_ok, transfers - reads_ok);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
